@@ hdl/quadratic_bezier_sampler_macros.svh @@
// assertion macros for the bezier sampler rtl
// expects clk and rst in the scope of each use, no other dependencies
`ifndef QUADRATIC_BEZIER_SAMPLER_MACROS_SVH
`define QUADRATIC_BEZIER_SAMPLER_MACROS_SVH

`ifndef ASSERT_OFF
`define QBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define QBS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define QBS_ASSERT(label, prop, msg)
`define QBS_ASSERT_NEVER(label, cond, msg)
`endif

`endif

@@ hdl/qbs_pkg.sv @@
// shared constants and types for the quadratic bezier sampler
// no dependencies
package qbs_pkg;

  localparam int SEG_BITS    = 6;
  localparam logic [SEG_BITS-1:0] SEG_RESET = 6'd39;

  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 3;
  localparam int REG_SEL_BIT = 2;

  typedef enum logic [0:0] {
    REG_SEGMENT_COUNT = 1'b0
  } reg_index_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

@@ hdl/qbs_curve_if.sv @@
// input channel of the sampler: one item is a triple of control points
// no dependencies
interface qbs_curve_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] ctrl_x;
  logic [COORD_BITS-1:0] ctrl_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic                  contour_end;

  modport source (
    output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, contour_end,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, contour_end,
    output ready
  );
endinterface

@@ hdl/qbs_point_if.sv @@
// output channel of the sampler: one item is a sampled curve point
// no dependencies
interface qbs_point_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  curve_last;
  logic                  contour_last;

  modport source (
    output valid, point_x, point_y, curve_last, contour_last,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, curve_last, contour_last,
    output ready
  );
endinterface

@@ hdl/qbs_recip.sv @@
// bit-serial reciprocal unit: quotient = floor(2^SHIFT / divisor)
// one quotient bit per cycle, no package dependencies
module qbs_recip #(
  parameter int SQ_BITS = 12,
  parameter int SHIFT   = 24,
  localparam int RECIP_BITS = SHIFT + 1,
  localparam int CNT_BITS   = $clog2(SHIFT + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SQ_BITS-1:0]    divisor,
  output logic                  busy,
  output logic [RECIP_BITS-1:0] quotient
);

  logic [CNT_BITS-1:0] cnt;
  logic [SQ_BITS-1:0]  rem;
  logic [SQ_BITS:0]    trial;
  logic [SQ_BITS:0]    diff;
  logic                take;

  // dividend is a one followed by SHIFT zeros, fed msb first
  assign trial = {rem, (cnt == '0)};
  assign diff  = trial - {1'b0, divisor};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_BITS'(SHIFT)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? diff[SQ_BITS-1:0] : trial[SQ_BITS-1:0];
      quotient <= {quotient[RECIP_BITS-2:0], take};
    end
  end

endmodule

@@ hdl/qbs_front.sv @@
// front end: segment count register, divisor set-up and item intake
// uses qbs_pkg, qbs_curve_if and qbs_recip
module qbs_front #(
  parameter int COORD_BITS   = 12,
  parameter int MAX_SEGMENTS = 63,
  localparam int IDX_BITS   = $clog2(MAX_SEGMENTS + 1),
  localparam int SQ_BITS    = 2 * IDX_BITS,
  localparam int SHIFT      = COORD_BITS + SQ_BITS,
  localparam int RECIP_BITS = SHIFT + 1,
  localparam int ITEM_BITS  = 6 * COORD_BITS + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qbs_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [qbs_pkg::DATA_BITS-1:0]  pwdata,
  output logic [qbs_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  qbs_curve_if.sink                      curve,
  output logic                           push_valid,
  input  logic                           push_ready,
  output logic [ITEM_BITS-1:0]           push_data,
  output logic [IDX_BITS-1:0]            seg_n,
  output logic [SQ_BITS-1:0]             seg_sq,
  output logic [RECIP_BITS-1:0]          recip
);
  import qbs_pkg::*;

  logic [SEG_BITS-1:0] seg;
  logic                seg_wr;
  logic                start;
  logic                recip_busy;
  logic                open;
  logic                single;
  logic [IDX_BITS-1:0] n_eff;
  reg_index_t          reg_idx;

  assign reg_idx = reg_index_t'(paddr[REG_SEL_BIT]);
  assign pready  = 1'b1;
  assign seg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_SEGMENT_COUNT);

  always_comb begin
    case (reg_idx)
      REG_SEGMENT_COUNT: prdata = DATA_BITS'(seg);
      default:           prdata = '0;
    endcase
  end

  assign n_eff = (seg > SEG_BITS'(MAX_SEGMENTS)) ? IDX_BITS'(MAX_SEGMENTS) : IDX_BITS'(seg);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg   <= SEG_RESET;
      start <= 1'b1;
    end else begin
      if (seg_wr) seg <= pwdata[SEG_BITS-1:0];
      start <= seg_wr;
    end
  end

  // zero segments is sampled as a single point with unit divisor
  always_ff @(posedge clk) begin
    seg_n  <= n_eff;
    seg_sq <= (n_eff == '0) ? SQ_BITS'(1) : SQ_BITS'(n_eff) * SQ_BITS'(n_eff);
  end

  qbs_recip #(
    .SQ_BITS (SQ_BITS),
    .SHIFT   (SHIFT)
  ) u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .divisor  (seg_sq),
    .busy     (recip_busy),
    .quotient (recip)
  );

  // no intake while the reciprocal is being rebuilt
  assign open        = !recip_busy && !start;
  assign single      = (seg_n == '0);
  assign push_valid  = curve.valid && open;
  assign curve.ready = push_ready && open;
  assign push_data   = {curve.start_x, curve.start_y, curve.ctrl_x, curve.ctrl_y,
                        curve.end_x, curve.end_y, curve.contour_end, single};

endmodule

@@ hdl/qbs_fifo.sv @@
// short item queue between the front and back ends
// uses qbs_pkg
module qbs_fifo #(
  parameter int WIDTH = 74
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import qbs_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != CNT_BITS'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_data;
  end

endmodule

@@ hdl/qbs_back.sv @@
// back end: sample sequencer and blend / divide pipeline, one point per cycle unless the output stalls
// uses qbs_point_if and the assertion macros
`include "quadratic_bezier_sampler_macros.svh"

module qbs_back #(
  parameter int COORD_BITS   = 12,
  parameter int MAX_SEGMENTS = 63,
  localparam int IDX_BITS   = $clog2(MAX_SEGMENTS + 1),
  localparam int SQ_BITS    = 2 * IDX_BITS,
  localparam int SHIFT      = COORD_BITS + SQ_BITS,
  localparam int RECIP_BITS = SHIFT + 1,
  localparam int PROD_BITS  = SHIFT + RECIP_BITS,
  localparam int ITEM_BITS  = 6 * COORD_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  logic [ITEM_BITS-1:0]  pop_data,
  input  logic [IDX_BITS-1:0]   seg_n,
  input  logic [SQ_BITS-1:0]    seg_sq,
  input  logic [RECIP_BITS-1:0] recip,
  qbs_point_if.source           point
);

  localparam int AXES = 2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state;
  logic [IDX_BITS-1:0] k;

  // current item
  logic [COORD_BITS-1:0] cur_a [AXES];
  logic [COORD_BITS-1:0] cur_b [AXES];
  logic [COORD_BITS-1:0] cur_c [AXES];
  logic                  cur_flag;
  logic                  cur_single;

  logic [COORD_BITS-1:0] in_a [AXES];
  logic [COORD_BITS-1:0] in_b [AXES];
  logic [COORD_BITS-1:0] in_c [AXES];
  logic                  in_flag;
  logic                  in_single;

  logic en;
  logic issue;
  logic at_last;

  // stage registers
  logic v1, v2, v3, v4, v5, vo;
  logic last1, last2, last3, last4, last5, last_o;
  logic flag1, flag2, flag3, flag4, flag5, flag_o;

  logic [SQ_BITS-1:0]    w0, w1, w2;
  logic [COORD_BITS-1:0] a1 [AXES];
  logic [COORD_BITS-1:0] b1 [AXES];
  logic [COORD_BITS-1:0] c1 [AXES];
  logic [SHIFT-1:0]      pa [AXES];
  logic [SHIFT-1:0]      pb [AXES];
  logic [SHIFT-1:0]      pc [AXES];
  logic [SHIFT-1:0]      num3 [AXES];
  logic [SHIFT-1:0]      num4 [AXES];
  logic [COORD_BITS-1:0] q4 [AXES];
  logic [SHIFT-1:0]      num5 [AXES];
  logic [SHIFT-1:0]      qd5 [AXES];
  logic [COORD_BITS-1:0] q5 [AXES];
  logic [COORD_BITS-1:0] pt [AXES];

  // combinational per stage
  logic [IDX_BITS-1:0]   r;
  logic [SQ_BITS-1:0]    rk;
  logic [PROD_BITS-1:0]  prod [AXES];
  logic [SHIFT-1:0]      rem [AXES];
  logic [COORD_BITS-1:0] q_fix [AXES];
  logic [SQ_BITS:0]      sq_twice;

  assign {in_a[0], in_a[1], in_b[0], in_b[1], in_c[0], in_c[1], in_flag, in_single} = pop_data;

  assign en        = !vo || point.ready;
  assign at_last   = (k == seg_n);
  assign issue     = (state == ST_RUN) && en;
  assign pop_ready = (state == ST_IDLE) || (issue && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_RUN;
            k     <= '0;
          end
        end
        ST_RUN: begin
          if (issue && at_last) begin
            state <= pop_valid ? ST_RUN : ST_IDLE;
            k     <= '0;
          end else if (issue) begin
            k <= k + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          k     <= '0;
        end
      endcase
      if (pop_valid && pop_ready) begin
        cur_a      <= in_a;
        cur_b      <= in_b;
        cur_c      <= in_c;
        cur_flag   <= in_flag;
        cur_single <= in_single;
      end
    end
  end

  // bernstein weights times n squared
  assign r  = seg_n - k;
  assign rk = SQ_BITS'(r) * SQ_BITS'(k);

  always_comb begin
    for (int ax = 0; ax < AXES; ax++) begin
      prod[ax]  = PROD_BITS'(num3[ax]) * PROD_BITS'(recip);
      rem[ax]   = num5[ax] - qd5[ax];
      // the reciprocal estimate is low by at most one
      q_fix[ax] = (rem[ax] >= SHIFT'(seg_sq)) ? q5[ax] + 1'b1 : q5[ax];
    end
  end

  assign sq_twice = {seg_sq, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      vo <= 1'b0;
    end else if (en) begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      vo <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w0    <= cur_single ? SQ_BITS'(1) : SQ_BITS'(r) * SQ_BITS'(r);
      w1    <= {rk[SQ_BITS-2:0], 1'b0};
      w2    <= SQ_BITS'(k) * SQ_BITS'(k);
      a1    <= cur_a;
      b1    <= cur_b;
      c1    <= cur_c;
      last1 <= at_last;
      flag1 <= at_last && cur_flag;

      last2  <= last1;
      flag2  <= flag1;
      last3  <= last2;
      flag3  <= flag2;
      last4  <= last3;
      flag4  <= flag3;
      last5  <= last4;
      flag5  <= flag4;
      last_o <= last5;
      flag_o <= flag5;

      for (int ax = 0; ax < AXES; ax++) begin
        pa[ax]   <= SHIFT'(w0) * SHIFT'(a1[ax]);
        pb[ax]   <= SHIFT'(w1) * SHIFT'(b1[ax]);
        pc[ax]   <= SHIFT'(w2) * SHIFT'(c1[ax]);
        num3[ax] <= SHIFT'(pa[ax] + pb[ax] + pc[ax]);
        num4[ax] <= num3[ax];
        q4[ax]   <= prod[ax][SHIFT +: COORD_BITS];
        num5[ax] <= num4[ax];
        q5[ax]   <= q4[ax];
        qd5[ax]  <= SHIFT'(q4[ax]) * SHIFT'(seg_sq);
        pt[ax]   <= q_fix[ax];
      end
    end
  end

  assign point.valid        = vo;
  assign point.point_x      = pt[0];
  assign point.point_y      = pt[1];
  assign point.curve_last   = last_o;
  assign point.contour_last = flag_o;

  `QBS_ASSERT(a_k_in_range, (state == ST_RUN) |-> (k <= seg_n), "sample index past segment count")
  `QBS_ASSERT(a_refill, (issue && at_last && pop_valid) |=> ((state == ST_RUN) && (k == '0)), "next curve not started at index zero")
  `QBS_ASSERT(a_quot_err, v5 |-> ((rem[0] < sq_twice) && (rem[1] < sq_twice)), "reciprocal quotient off by more than one")
  `QBS_ASSERT_NEVER(a_flag_alone, vo && flag_o && !last_o, "contour flag on a point that is not last")

endmodule

@@ hdl/quadratic_bezier_sampler.sv @@
// Quadratic bezier sampler. Each input item is a control point triple; for a
// segment count n (register 0, saturated to MAX_SEGMENTS) it yields n+1 points
// k = 0..n, per axis ((n-k)^2*P0 + 2(n-k)k*P1 + k^2*P2) / n^2 truncated, with
// curve_last on point n and contour_last copying contour_end there; n = 0
// gives P0 alone. The sample sequencer issues one k per cycle, unless the
// output stalls, into a six-stage blend and divide pipeline, and a two-entry
// queue takes the next item while the current one is being sampled. The
// division is a multiply by a stored reciprocal of n^2 with a one-step
// correction; that reciprocal is rebuilt bit-serially after reset and after
// every segment count write, and no item is taken while that runs.
module quadratic_bezier_sampler #(
  parameter int COORD_BITS   = 12,
  parameter int MAX_SEGMENTS = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qbs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [qbs_pkg::DATA_BITS-1:0] pwdata,
  output logic [qbs_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  qbs_curve_if.sink                     curve,
  qbs_point_if.source                   point
);

  localparam int IDX_BITS   = $clog2(MAX_SEGMENTS + 1);
  localparam int SQ_BITS    = 2 * IDX_BITS;
  localparam int RECIP_BITS = COORD_BITS + SQ_BITS + 1;
  localparam int ITEM_BITS  = 6 * COORD_BITS + 2;

  logic                  push_valid;
  logic                  push_ready;
  logic [ITEM_BITS-1:0]  push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [ITEM_BITS-1:0]  pop_data;
  logic [IDX_BITS-1:0]   seg_n;
  logic [SQ_BITS-1:0]    seg_sq;
  logic [RECIP_BITS-1:0] recip;

  qbs_front #(
    .COORD_BITS   (COORD_BITS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .curve      (curve),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .seg_n      (seg_n),
    .seg_sq     (seg_sq),
    .recip      (recip)
  );

  qbs_fifo #(
    .WIDTH (ITEM_BITS)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  qbs_back #(
    .COORD_BITS   (COORD_BITS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .seg_n     (seg_n),
    .seg_sq    (seg_sq),
    .recip     (recip),
    .point     (point)
  );

endmodule
